[src/text_to_integer_parser_core_assert.svh]
// assertion macros for the text to integer parser
// expects clk and rst_n in the scope where a macro is used
`ifndef TEXT_TO_INTEGER_PARSER_CORE_ASSERT_SVH
`define TEXT_TO_INTEGER_PARSER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TTIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define TTIP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/ttip_pkg.sv]
// shared types, codes and the digit decoder for the text to integer parser
// no dependencies
package ttip_pkg;

    typedef enum logic [2:0]
    {
        PH_START      = 3'd0,
        PH_AFTER_SIGN = 3'd1,
        PH_AFTER_ZERO = 3'd2,
        PH_NEED_BODY  = 3'd3,
        PH_BODY       = 3'd4,
        PH_FAILED     = 3'd5
    } phase_t;

    typedef struct packed
    {
        logic       ok;
        logic [5:0] val;
    } digit_t;

    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_LOWER_O    = 8'h6F;
    localparam logic [7:0] CH_LOWER_D    = 8'h64;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CASE_BIT      = 8'h20;

    localparam logic [4:0] RADIX_BIN = 5'd2;
    localparam logic [4:0] RADIX_OCT = 5'd8;
    localparam logic [4:0] RADIX_DEC = 5'd10;
    localparam logic [4:0] RADIX_HEX = 5'd16;

    localparam logic [2:0] FMT_MAG    = 3'd0;
    localparam logic [2:0] FMT_UINT64 = 3'd1;
    localparam logic [2:0] FMT_INT64  = 3'd2;
    localparam logic [2:0] FMT_INT32  = 3'd3;
    localparam logic [2:0] FMT_UINT32 = 3'd4;

    localparam logic [1:0] ST_FAIL = 2'd0;
    localparam logic [1:0] ST_POS  = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;

    // 0-9, a-z, A-Z map to 0..35, anything else is no digit
    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t d;
        d.ok  = 1'b1;
        d.val = '0;
        if (c inside {[8'h41:8'h5A]})
        begin
            d.val = 6'(c - 8'h41) + 6'd10;
        end
        else if (c inside {[8'h61:8'h7A]})
        begin
            d.val = 6'(c - 8'h61) + 6'd10;
        end
        else if (c inside {[8'h30:8'h39]})
        begin
            d.val = 6'(c - 8'h30);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

[src/text_to_integer_parser_core.sv]
// text to integer parser: one character per transaction, one result per text
// depends on ttip_pkg and text_to_integer_parser_core_assert.svh
// usage
//   s_* stream carries the text: s_tdata is the character code, s_tlast set
//   marks the end transaction (its character is ignored). an optional sign,
//   an optional 0b/0o/0d/0x prefix (bare leading zero means octal) and
//   underscores among the digits are understood.
//   m_* stream carries one result per end transaction: m_tuser is the status
//   (0 failed, 1 ok, 2 ok negative in magnitude format), m_tdata the value checked
//   against result_format, written through cfg_wr_en / cfg_wr_data.
// timing
//   every character goes through an input register and then one pass of
//   shift-add, digit compare and 68-bit overflow check into the state
//   registers; one transaction is accepted per cycle while s_tready is high.
//   a result passes the input register and then the output registers to m_*.
// reset and stall
//   reset clears the parse state, the format (magnitude with sign) and both
//   valid flags. while a result waits on m_tready, characters keep flowing;
//   only a following end transaction holds in the input register, and
//   s_tready drops once that register is full behind it.
`include "text_to_integer_parser_core_assert.svh"

module text_to_integer_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,   // result_format
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] char_code
    input  logic        s_tlast,       // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,       // [63:0] value
    output logic [1:0]  m_tuser        // [1:0] status
);
    import ttip_pkg::*;

    logic        fmt_is_mag;
    logic [2:0]  format_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [7:0]  in_char_reg;
    logic        in_end_reg;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic [4:0]  radix_reg;
    logic [4:0]  radix_next;
    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic        minus_reg;
    logic        minus_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  out_status_reg;
    logic [63:0] out_value_reg;

    logic        advance;
    logic        proc;
    logic        take_in;
    logic        take_body;
    logic [4:0]  eff_radix;
    digit_t      dig;
    logic [67:0] prod;
    logic [67:0] sum;
    phase_t      body_phase;
    logic [63:0] body_acc;
    logic        res_ok;
    logic [63:0] res_mag;
    logic [63:0] res_neg_mag;
    logic [1:0]  res_status;
    logic [63:0] res_value;

    // a non-end item never waits on the output side
    assign advance  = !in_end_reg || !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign take_in  = s_tvalid && s_tready;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_value_reg;
    assign m_tuser    = out_status_reg;
    assign fmt_is_mag = format_reg == FMT_MAG;

    // digit body step with the radix in force for this character
    always_comb
    begin
        case (phase_reg)
            PH_START, PH_AFTER_SIGN: eff_radix = RADIX_DEC;
            PH_AFTER_ZERO:           eff_radix = RADIX_OCT;
            default:                 eff_radix = radix_reg;
        endcase
        dig = digit_of(in_char_reg);
        case (eff_radix)
            RADIX_BIN: prod = {3'b000, acc_reg, 1'b0};
            RADIX_OCT: prod = {1'b0, acc_reg, 3'b000};
            RADIX_HEX: prod = {acc_reg, 4'b0000};
            default:   prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0};
        endcase
        sum = prod + 68'(dig.val);
        body_phase = PH_BODY;
        body_acc   = acc_reg;
        if (in_char_reg == CH_UNDERSCORE)
        begin
            body_phase = PH_BODY;
        end
        else if (!dig.ok || dig.val >= {1'b0, eff_radix} || (|sum[67:64]))
        begin
            body_phase = PH_FAILED;
        end
        else
        begin
            body_acc = sum[63:0];
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        take_body  = 1'b0;
        if (proc)
        begin
            if (in_end_reg)
            begin
                phase_next = PH_START;
                radix_next = RADIX_DEC;
                acc_next   = '0;
                minus_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        if (in_char_reg == CH_MINUS)
                        begin
                            minus_next = 1'b1;
                            phase_next = PH_AFTER_SIGN;
                        end
                        else if (in_char_reg == CH_PLUS)
                        begin
                            phase_next = PH_AFTER_SIGN;
                        end
                        else if (in_char_reg == CH_ZERO)
                        begin
                            phase_next = PH_AFTER_ZERO;
                        end
                        else
                        begin
                            radix_next = RADIX_DEC;
                            take_body  = 1'b1;
                        end
                    end
                    PH_AFTER_SIGN:
                    begin
                        if (in_char_reg == CH_ZERO)
                        begin
                            phase_next = PH_AFTER_ZERO;
                        end
                        else
                        begin
                            radix_next = RADIX_DEC;
                            take_body  = 1'b1;
                        end
                    end
                    PH_AFTER_ZERO:
                    begin
                        case (in_char_reg | CASE_BIT)
                            CH_LOWER_B:
                            begin
                                radix_next = RADIX_BIN;
                                phase_next = PH_NEED_BODY;
                            end
                            CH_LOWER_O:
                            begin
                                radix_next = RADIX_OCT;
                                phase_next = PH_NEED_BODY;
                            end
                            CH_LOWER_D:
                            begin
                                radix_next = RADIX_DEC;
                                phase_next = PH_NEED_BODY;
                            end
                            CH_LOWER_X:
                            begin
                                radix_next = RADIX_HEX;
                                phase_next = PH_NEED_BODY;
                            end
                            default:
                            begin
                                // bare leading zero: this character is an octal digit
                                radix_next = RADIX_OCT;
                                take_body  = 1'b1;
                            end
                        endcase
                    end
                    PH_NEED_BODY, PH_BODY:
                    begin
                        take_body = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_FAILED;
                    end
                endcase
                if (take_body)
                begin
                    phase_next = body_phase;
                    acc_next   = body_acc;
                end
            end
        end
    end

    // result for an end item
    always_comb
    begin
        res_ok      = phase_reg == PH_BODY || phase_reg == PH_AFTER_ZERO;
        res_mag     = (phase_reg == PH_AFTER_ZERO) ? 64'd0 : acc_reg;
        res_neg_mag = 64'd0 - res_mag;
        res_status  = ST_FAIL;
        res_value   = '0;
        if (res_ok)
        begin
            case (format_reg)
                FMT_MAG:
                begin
                    res_status = minus_reg ? ST_NEG : ST_POS;
                    res_value  = res_mag;
                end
                FMT_UINT64:
                begin
                    if (!minus_reg)
                    begin
                        res_status = ST_POS;
                        res_value  = res_mag;
                    end
                end
                FMT_INT64:
                begin
                    if (minus_reg)
                    begin
                        if (res_mag <= 64'h8000_0000_0000_0000)
                        begin
                            res_status = ST_POS;
                            res_value  = res_neg_mag;
                        end
                    end
                    else if (res_mag <= 64'h7FFF_FFFF_FFFF_FFFF)
                    begin
                        res_status = ST_POS;
                        res_value  = res_mag;
                    end
                end
                FMT_INT32:
                begin
                    if (minus_reg)
                    begin
                        if (res_mag <= 64'h0000_0000_8000_0000)
                        begin
                            res_status = ST_POS;
                            res_value  = {32'd0, res_neg_mag[31:0]};
                        end
                    end
                    else if (res_mag <= 64'h0000_0000_7FFF_FFFF)
                    begin
                        res_status = ST_POS;
                        res_value  = res_mag;
                    end
                end
                FMT_UINT32:
                begin
                    if (!minus_reg && res_mag <= 64'h0000_0000_FFFF_FFFF)
                    begin
                        res_status = ST_POS;
                        res_value  = res_mag;
                    end
                end
                default:
                begin
                    res_status = ST_FAIL;
                end
            endcase
        end
    end

    always_comb
    begin
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (proc)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
        if (proc && in_end_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg    <= FMT_MAG;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_START;
            radix_reg     <= RADIX_DEC;
            acc_reg       <= '0;
            minus_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                format_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            radix_reg     <= radix_next;
            acc_reg       <= acc_next;
            minus_reg     <= minus_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_char_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
        if (proc && in_end_reg)
        begin
            out_status_reg <= res_status;
            out_value_reg  <= res_value;
        end
    end

    `TTIP_ASSERT_IMP(a_fail_value_zero, m_tvalid && m_tuser == ST_FAIL, m_tdata == 64'd0,
        "failed result carries a nonzero value")
    `TTIP_ASSERT_NXT(a_end_restarts, proc && in_end_reg,
        m_tvalid && phase_reg == PH_START && acc_reg == 64'd0 && !minus_reg,
        "end transaction did not post a result and restart the parse")
    `TTIP_ASSERT_NXT(a_failed_sticky, phase_reg == PH_FAILED && !(proc && in_end_reg),
        phase_reg == PH_FAILED, "failed parse resumed before the end transaction")
    `TTIP_ASSERT_IMP(a_acc_only_in_body, acc_reg != 64'd0,
        phase_reg == PH_BODY || phase_reg == PH_FAILED,
        "accumulator nonzero outside the digit body")
    `TTIP_ASSERT_IMP(a_neg_only_mag, proc && in_end_reg && res_status == ST_NEG, fmt_is_mag,
        "negative status outside the magnitude format")

endmodule
